FILE: rtl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the CAN message segmenter.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned NodeW     = 5;
  localparam int unsigned SegNumW   = 6;
  localparam int unsigned CountW    = 4;
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned DataW     = 8 * FrameBytes;
  localparam int unsigned IdW       = 32;

  localparam logic [NodeW-1:0]   SrcNodeReset   = 5'd1;
  localparam logic [SegNumW-1:0] SegNumFirst    = 6'd1;
  localparam int unsigned        FifoDepthDef   = 2;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_END    = 2'd3
  } seg_kind_e;

  // One finished frame, as handed from the packer to the output stage.
  typedef struct packed {
    seg_kind_e          kind;
    logic [SegNumW-1:0] seg_num;
    logic [NodeW-1:0]   dest;
    logic [CountW-1:0]  count;
    logic [DataW-1:0]   data;
  } frame_desc_t;

endpackage

FILE: rtl/cms_packer.sv
// ----------------------------------------------------------------------------
// cms_packer
// Front end: packs message bytes into frames and classifies each frame.
// ----------------------------------------------------------------------------
module cms_packer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            payload_byte_i,
  input  logic [cms_pkg::NodeW-1:0] dest_node_i,
  input  logic                  last_byte_i,
  output logic                  desc_valid_o,
  output cms_pkg::frame_desc_t  desc_o
);
  import cms_pkg::*;

  logic [DataW-1:0]   buf_q, buf_d, buf_ins;
  logic [2:0]         fill_q, fill_d;
  logic               started_q, started_d;
  logic               sent_q, sent_d;
  logic [SegNumW-1:0] seg_q, seg_d;
  logic [NodeW-1:0]   dest_q, dest_d;
  logic [CountW-1:0]  count;
  logic               emit;
  seg_kind_e          kind;

  always_comb begin
    buf_ins = buf_q | (DataW'(payload_byte_i) << {fill_q, 3'b000});
    count   = CountW'(fill_q) + CountW'(1);
    emit    = last_byte_i || (fill_q == 3'd7);
    dest_d  = started_q ? dest_q : dest_node_i;

    priority if (last_byte_i) begin
      kind = sent_q ? KIND_END : KIND_NONE;
    end else if (!sent_q) begin
      kind = KIND_FIRST;
    end else begin
      kind = KIND_MIDDLE;
    end

    buf_d     = buf_ins;
    fill_d    = count[2:0];
    started_d = 1'b1;
    sent_d    = sent_q;
    seg_d     = seg_q;
    if (emit) begin
      buf_d  = '0;
      fill_d = '0;
      if (last_byte_i) begin
        started_d = 1'b0;
        sent_d    = 1'b0;
        seg_d     = SegNumFirst;
      end else begin
        // wrap modulo 64 so the number never reaches the kind bits
        if (sent_q) seg_d = seg_q + SegNumW'(1);
        sent_d = 1'b1;
      end
    end
  end

  assign desc_valid_o   = accept_i && emit;
  assign desc_o.kind    = kind;
  assign desc_o.seg_num = (kind == KIND_MIDDLE) ? seg_q : '0;
  assign desc_o.dest    = dest_d;
  assign desc_o.count   = count;
  assign desc_o.data    = buf_ins;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= '0;
      fill_q    <= '0;
      started_q <= 1'b0;
      sent_q    <= 1'b0;
      seg_q     <= SegNumFirst;
      dest_q    <= '0;
    end else if (accept_i) begin
      buf_q     <= buf_d;
      fill_q    <= fill_d;
      started_q <= started_d;
      sent_q    <= sent_d;
      seg_q     <= seg_d;
      dest_q    <= dest_d;
    end
  end

endmodule

FILE: rtl/cms_fifo.sv
// ----------------------------------------------------------------------------
// cms_fifo
// Short frame queue between the packer and the output stage.
// ----------------------------------------------------------------------------
module cms_fifo #(
  parameter int unsigned Depth = cms_pkg::FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  cms_pkg::frame_desc_t wdata_i,
  input  logic                 rd_i,
  output cms_pkg::frame_desc_t rdata_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import cms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_desc_t      mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= ptr_next(wptr_q);
      if (do_rd) rptr_q <= ptr_next(rptr_q);
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/cms_frame_out.sv
// ----------------------------------------------------------------------------
// cms_frame_out
// Back end: builds the identifier and holds the frame for the receiver.
// ----------------------------------------------------------------------------
module cms_frame_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cms_pkg::NodeW-1:0] cfg_wdata_i,
  input  logic                      q_empty_i,
  input  cms_pkg::frame_desc_t      q_data_i,
  output logic                      q_rd_o,
  input  logic                      pop,
  output logic                      empty,
  output logic [cms_pkg::IdW-1:0]   frame_id_o,
  output logic [cms_pkg::CountW-1:0] byte_count_o,
  output logic [cms_pkg::DataW-1:0] frame_data_o
);
  import cms_pkg::*;

  logic [NodeW-1:0] src_q;
  logic             valid_q;
  logic [IdW-1:0]   id_d;

  // refill the output register when it is free or being drained
  assign q_rd_o = !q_empty_i && (!valid_q || pop);
  assign empty  = !valid_q;

  assign id_d = {1'b1, 4'b0000, src_q, 1'b0, q_data_i.dest,
                 q_data_i.kind, q_data_i.seg_num, 8'h00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= SrcNodeReset;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) src_q <= cfg_wdata_i;
      if (q_rd_o) begin
        valid_q <= 1'b1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      frame_id_o   <= id_d;
      byte_count_o <= q_data_i.count;
      frame_data_o <= q_data_i.data;
    end
  end

endmodule

FILE: rtl/can_message_segmenter_top.sv
// ----------------------------------------------------------------------------
// can_message_segmenter_top
// Packs a byte stream into extended CAN frames with segment identifiers.
// ----------------------------------------------------------------------------
// Input channel: drive payload_byte_i, dest_node_i, last_byte_i and raise
// push; a byte transfers on a clock edge with push high and full low. One
// byte transfers per cycle while the frame queue has room.
// A frame is closed on its eighth byte or on a byte marked last_byte_i;
// dest_node_i is sampled on the first byte of each message only.
// Output channel: while empty is low, frame_id_o, byte_count_o and
// frame_data_o hold the oldest frame; it transfers on an edge with pop high.
// Path: a frame passes from the packer through the queue into the output
// register. Throughput: one byte per cycle and at most one frame per cycle
// while the frame queue has room.
// If the receiver stalls, frames collect in the queue (FifoDepth entries)
// plus the output register; full rises only when the queue is full.
// Reset clears the packer and the queue, empties the output register and sets the
// source node to 1. Write cfg_wdata_i with cfg_we_i only while idle.
// ----------------------------------------------------------------------------
module can_message_segmenter_top #(
  parameter int unsigned FifoDepth = cms_pkg::FifoDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cms_pkg::NodeW-1:0]  cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 payload_byte_i,
  input  logic [cms_pkg::NodeW-1:0]  dest_node_i,
  input  logic                       last_byte_i,
  input  logic                       pop,
  output logic                       empty,
  output logic [cms_pkg::IdW-1:0]    frame_id_o,
  output logic [cms_pkg::CountW-1:0] byte_count_o,
  output logic [cms_pkg::DataW-1:0]  frame_data_o
);
  import cms_pkg::*;

  logic        accept;
  logic        desc_valid;
  frame_desc_t desc, q_data;
  logic        q_full, q_empty, q_rd;

  assign full   = q_full;
  assign accept = push && !q_full;

  cms_packer u_packer (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .payload_byte_i,
    .dest_node_i,
    .last_byte_i,
    .desc_valid_o   (desc_valid),
    .desc_o         (desc)
  );

  cms_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i    (desc_valid),
    .wdata_i (desc),
    .rd_i    (q_rd),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cms_frame_out u_out (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop,
    .empty,
    .frame_id_o,
    .byte_count_o,
    .frame_data_o
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (byte_count_o != 4'd0 && byte_count_o <= 4'd8))
    else $error("frame byte count out of range");

  a_short_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && byte_count_o != 4'd8) |->
      (frame_id_o[15:14] == KIND_NONE || frame_id_o[15:14] == KIND_END))
    else $error("short frame not marked as final");

  a_seg_only_middle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_id_o[15:14] != KIND_MIDDLE) |-> (frame_id_o[13:8] == 6'd0))
    else $error("segment number on a non-middle frame");

  a_full_no_frame_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desc_valid && !q_full) |=> !q_empty)
    else $error("frame lost on its way into the queue");

endmodule
